@@ rtl/sensor_frame_receiver_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Sensor frame receiver assertion macros
// Shared concurrent assertion helpers; NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define SENSOR_FRAME_RECEIVER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SFR_ASSERT_NOW(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error(msg);

// next-cycle implication
`define SFR_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error(msg);

`else

`define SFR_ASSERT_NOW(label, clk, rst, a, b, msg)
`define SFR_ASSERT_NEXT(label, clk, rst, a, b, msg)

`endif

`endif

@@ rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Sensor frame receiver package
// Header codes, widths and the control structs between top and frame store.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h42;
  localparam logic [7:0] HDR_SECOND = 8'h4D;

  localparam int POS_W      = 6;
  localparam int BANK_IDX_W = 5;

  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic                  en;
    logic [BANK_IDX_W-1:0] idx;
  } store_rd_t;

endpackage

@@ rtl/sfr_store.sv @@
// ----------------------------------------------------------------------------
// Sensor frame receiver byte store
// Frame bytes held in an even and an odd bank so one big-endian word reads
// out per cycle; write by byte position, registered read by word index.
// ----------------------------------------------------------------------------
module sfr_store #(
  parameter int FRAME_BYTES = 32
) (
  input  logic                clk,
  input  sfr_pkg::store_wr_t  wr,
  input  sfr_pkg::store_rd_t  rd,
  output logic [15:0]         rd_word
);

  localparam int BD = (FRAME_BYTES + 1) / 2;
  localparam int BW = $clog2(BD);

  logic [7:0] even_mem [BD];
  logic [7:0] odd_mem  [BD];
  logic [7:0] even_q;
  logic [7:0] odd_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.pos[0]) begin
        odd_mem[wr.pos[BW:1]] <= wr.data;
      end else begin
        even_mem[wr.pos[BW:1]] <= wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      even_q <= even_mem[rd.idx[BW-1:0]];
      odd_q  <= odd_mem[rd.idx[BW-1:0]];
    end
  end

  assign rd_word = {even_q, odd_q};

endmodule

@@ rtl/sensor_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// Sensor frame receiver unit
// Byte-serial frame parser: header hunt, length check, 16-bit sum check and
// readout of the accepted frame as big-endian words.
// ----------------------------------------------------------------------------
// Each received byte is taken while byte_stall is low. When the last byte
// of a frame with a good length word and a good checksum arrives, byte_stall
// rises and the (FRAME_BYTES-2)/2 words are read from the banked byte store;
// each word passes the store read register and then the output register,
// and a new word is read only once the previous read has reached the output
// register. The last word may still wait in the output register while the
// next frame comes in. A bad frame does not raise byte_stall and gives no
// words. The store needs no clearing pass after reset.
`include "sensor_frame_receiver_unit_defines.svh"

module sensor_frame_receiver_unit #(
  parameter int FRAME_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  rx_byte,
  output logic        word_valid,
  input  logic        word_stall,
  output logic [3:0]  word_index,
  output logic [15:0] word_value,
  output logic        last_word
);

  localparam int WORDS = (FRAME_BYTES - 2) / 2;
  localparam int KW    = $clog2(WORDS);
  localparam int IW    = sfr_pkg::BANK_IDX_W;
  localparam int PW    = sfr_pkg::POS_W;

  localparam logic [PW-1:0] POS_LAST    = PW'(FRAME_BYTES - 1);
  localparam logic [PW-1:0] POS_SUM_END = PW'(FRAME_BYTES - 2);
  localparam logic [PW-1:0] POS_LEN_HI  = PW'(2);
  localparam logic [PW-1:0] POS_LEN_LO  = PW'(3);
  localparam logic [PW-1:0] POS_HDR2    = PW'(1);
  localparam logic [15:0]   LEN_WORD    = 16'(FRAME_BYTES - 4);
  localparam logic [KW-1:0] K_LAST      = KW'(WORDS - 1);

  localparam logic ST_RECV = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic          state;
  logic [PW-1:0] pos;
  logic [15:0]   sum;
  logic [7:0]    len_hi;
  logic          len_ok;
  logic [7:0]    chk_hi;
  logic [KW-1:0] k;
  logic          rd_pending;
  logic [3:0]    pend_idx;
  logic          pend_last;

  logic          byte_take;
  logic          word_take;
  logic          issue;
  logic [15:0]   sum_add;
  logic [15:0]   rd_word;

  sfr_pkg::store_wr_t wr;
  sfr_pkg::store_rd_t rd;

  assign byte_stall = (state == ST_EMIT);
  assign byte_take  = byte_valid && !byte_stall;
  assign word_take  = word_valid && !word_stall;
  assign issue      = (state == ST_EMIT) && !rd_pending && (!word_valid || !word_stall);
  assign sum_add    = sum + 16'(rx_byte);

  always_comb begin
    wr.en   = byte_take && (pos > POS_HDR2);
    wr.pos  = pos;
    wr.data = rx_byte;
    rd.en   = issue;
    rd.idx  = IW'(k) + IW'(1);
  end

  sfr_store #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_word (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_RECV;
      pos    <= '0;
      sum    <= '0;
      len_ok <= 1'b0;
      k      <= '0;
    end else if (byte_take) begin
      priority if (pos == '0) begin
        if (rx_byte == sfr_pkg::HDR_FIRST) begin
          sum <= 16'(rx_byte);
          pos <= POS_HDR2;
        end
      end else if (pos == POS_HDR2) begin
        priority if (rx_byte == sfr_pkg::HDR_SECOND) begin
          sum <= sum_add;
          pos <= POS_LEN_HI;
        end else if (rx_byte == sfr_pkg::HDR_FIRST) begin
          sum <= 16'(rx_byte);
        end else begin
          pos <= '0;
        end
      end else begin
        if (pos < POS_SUM_END) begin
          sum <= sum_add;
        end
        if (pos == POS_LEN_LO) begin
          len_ok <= ({len_hi, rx_byte} == LEN_WORD);
        end
        if (pos == POS_LAST) begin
          pos <= '0;
          if (len_ok && ({chk_hi, rx_byte} == sum)) begin
            state <= ST_EMIT;
            k     <= '0;
          end
        end else begin
          pos <= pos + PW'(1);
        end
      end
    end else if (issue) begin
      k <= k + KW'(1);
      if (k == K_LAST) begin
        state <= ST_RECV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      if (pos == POS_LEN_HI) begin
        len_hi <= rx_byte;
      end
      if (pos == POS_SUM_END) begin
        chk_hi <= rx_byte;
      end
    end
    if (issue) begin
      pend_idx  <= 4'(k);
      pend_last <= (k == K_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      word_valid <= 1'b0;
    end else begin
      rd_pending <= issue;
      if (rd_pending) begin
        word_valid <= 1'b1;
      end else if (word_take) begin
        word_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending) begin
      word_index <= pend_idx;
      word_value <= rd_word;
      last_word  <= pend_last;
    end
  end

  `SFR_ASSERT_NOW(a_load_slot_free, clk, rst, rd_pending, !word_valid, "output register busy on load")
  `SFR_ASSERT_NOW(a_no_write_in_emit, clk, rst, wr.en, state == ST_RECV, "store write during readout")
  `SFR_ASSERT_NOW(a_pos_idle_in_emit, clk, rst, state == ST_EMIT, pos == '0, "frame position not cleared during readout")

endmodule
